/* hdl/jetp_pkg.sv */
package jetp_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 16;

    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int PROD_W     = 2 * COORD_WIDTH;
    localparam int WIDE_W     = PROD_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (COORD_WIDTH > COUNT_WIDTH) ? COORD_WIDTH : COUNT_WIDTH;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0]      WIDE_MAX  = WIDE_W'(COORD_MAX);
    localparam logic signed [WIDE_W-1:0]      WIDE_MIN  = WIDE_W'(COORD_MIN);

    // Escape radius squared, 4.0 in the coordinate format.
    localparam logic [COORD_WIDTH:0] ESCAPE_LIMIT = (COORD_WIDTH+1)'(1) << (FRAC_BITS + 2);

    localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_C_REAL,
        REG_C_IMAG,
        REG_MAX_ITER,
        REG_X_ORIGIN,
        REG_Y_ORIGIN,
        REG_X_STEP,
        REG_Y_STEP
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_START,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] c_real;
        logic signed [COORD_WIDTH-1:0] c_imag;
        logic [COUNT_WIDTH-1:0]        max_iterations;
        logic signed [COORD_WIDTH-1:0] x_origin;
        logic signed [COORD_WIDTH-1:0] y_origin;
        logic signed [COORD_WIDTH-1:0] x_step;
        logic signed [COORD_WIDTH-1:0] y_step;
    } cfg_t;

    typedef struct packed {
        logic sel_init;
        logic load_in;
        logic load_start;
        logic update;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic stop;
    } status_t;

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [COORD_WIDTH-1:0] r;
        if (v > WIDE_MAX)
        begin
            r = COORD_MAX;
        end
        else if (v < WIDE_MIN)
        begin
            r = COORD_MIN;
        end
        else
        begin
            r = v[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/jetp_cfg_regs.sv */
module jetp_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [jetp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jetp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output jetp_pkg::cfg_t                    cfg
);
    import jetp_pkg::*;

    localparam cfg_t CFG_RESET = '{'0, '0, MAX_ITER_RESET, '0, '0, '0, '0};

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_C_REAL:   cfg_next.c_real         = cfg_data[COORD_WIDTH-1:0];
                REG_C_IMAG:   cfg_next.c_imag         = cfg_data[COORD_WIDTH-1:0];
                REG_MAX_ITER: cfg_next.max_iterations = cfg_data[COUNT_WIDTH-1:0];
                REG_X_ORIGIN: cfg_next.x_origin       = cfg_data[COORD_WIDTH-1:0];
                REG_Y_ORIGIN: cfg_next.y_origin       = cfg_data[COORD_WIDTH-1:0];
                REG_X_STEP:   cfg_next.x_step         = cfg_data[COORD_WIDTH-1:0];
                REG_Y_STEP:   cfg_next.y_step         = cfg_data[COORD_WIDTH-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/jetp_datapath.sv */
module jetp_datapath (
    input  logic                              clk,
    input  jetp_pkg::cfg_t                    cfg,
    input  jetp_pkg::cmd_t                    cmd,
    output jetp_pkg::status_t                 status,
    input  logic [jetp_pkg::IDX_W-1:0]        pixel_column,
    input  logic [jetp_pkg::IDX_W-1:0]        pixel_row,
    output logic [jetp_pkg::COUNT_WIDTH-1:0]  escape_count,
    output logic [jetp_pkg::IDX_W-1:0]        out_column,
    output logic [jetp_pkg::IDX_W-1:0]        out_row
);
    import jetp_pkg::*;

    logic [IDX_W-1:0]              col_reg, col_next;
    logic [IDX_W-1:0]              row_reg, row_next;
    logic signed [COORD_WIDTH-1:0] zr_reg, zr_next;
    logic signed [COORD_WIDTH-1:0] zi_reg, zi_next;
    logic [COUNT_WIDTH-1:0]        cnt_reg, cnt_next;
    logic signed [PROD_W-1:0]      prod0_reg, prod0_next;
    logic signed [PROD_W-1:0]      prod1_reg, prod1_next;
    logic signed [PROD_W-1:0]      prod2_reg, prod2_next;
    logic [COUNT_WIDTH-1:0]        escape_count_reg, escape_count_next;
    logic [IDX_W-1:0]              out_column_reg, out_column_next;
    logic [IDX_W-1:0]              out_row_reg, out_row_next;

    logic signed [COORD_WIDTH-1:0] mul0_a, mul0_b, mul1_a, mul1_b;
    logic signed [COORD_WIDTH-1:0] x_start, y_start;
    logic signed [COORD_WIDTH-1:0] sq_r, sq_i, cross_term, diff, ci, new_r, new_i;
    logic [COORD_WIDTH:0]          mag_sq;
    logic                          escaped;

    always_comb
    begin
        if (cmd.sel_init)
        begin
            mul0_a = $signed(COORD_WIDTH'(col_reg));
            mul0_b = cfg.x_step;
            mul1_a = $signed(COORD_WIDTH'(row_reg));
            mul1_b = cfg.y_step;
        end
        else
        begin
            mul0_a = zr_reg;
            mul0_b = zr_reg;
            mul1_a = zi_reg;
            mul1_b = zi_reg;
        end
        prod0_next = mul0_a * mul0_b;
        prod1_next = mul1_a * mul1_b;
        prod2_next = zr_reg * zi_reg;
    end

    always_comb
    begin
        x_start = sat_coord(WIDE_W'(cfg.x_origin) + WIDE_W'(sat_coord(WIDE_W'(prod0_reg))));
        y_start = sat_coord(WIDE_W'(cfg.y_origin) + WIDE_W'(sat_coord(WIDE_W'(prod1_reg))));

        sq_r       = sat_coord(WIDE_W'(prod0_reg >>> FRAC_BITS));
        sq_i       = sat_coord(WIDE_W'(prod1_reg >>> FRAC_BITS));
        cross_term = sat_coord(WIDE_W'(prod2_reg >>> (FRAC_BITS - 1)));
        mag_sq     = {1'b0, sq_r} + {1'b0, sq_i};
        escaped    = (mag_sq >= ESCAPE_LIMIT);

        diff  = sq_r - sq_i;
        ci    = sat_coord(-WIDE_W'(cfg.c_imag));
        new_r = sat_coord(WIDE_W'(diff) + WIDE_W'(cfg.c_real));
        new_i = sat_coord(WIDE_W'(cross_term) + WIDE_W'(ci));

        status.stop = escaped || (cnt_reg >= cfg.max_iterations);
    end

    always_comb
    begin
        col_next          = cmd.load_in ? pixel_column : col_reg;
        row_next          = cmd.load_in ? pixel_row : row_reg;
        zr_next           = zr_reg;
        zi_next           = zi_reg;
        cnt_next          = cnt_reg;
        escape_count_next = escape_count_reg;
        out_column_next   = out_column_reg;
        out_row_next      = out_row_reg;
        if (cmd.load_start)
        begin
            zr_next  = x_start;
            zi_next  = y_start;
            cnt_next = '0;
        end
        else if (cmd.update)
        begin
            zr_next  = new_r;
            zi_next  = new_i;
            cnt_next = cnt_reg + COUNT_WIDTH'(1);
        end
        if (cmd.load_out)
        begin
            escape_count_next = cnt_reg;
            out_column_next   = col_reg;
            out_row_next      = row_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg          <= col_next;
        row_reg          <= row_next;
        zr_reg           <= zr_next;
        zi_reg           <= zi_next;
        cnt_reg          <= cnt_next;
        prod0_reg        <= prod0_next;
        prod1_reg        <= prod1_next;
        prod2_reg        <= prod2_next;
        escape_count_reg <= escape_count_next;
        out_column_reg   <= out_column_next;
        out_row_reg      <= out_row_next;
    end

    assign escape_count = escape_count_reg;
    assign out_column   = out_column_reg;
    assign out_row      = out_row_reg;

endmodule

/* hdl/jetp_ctrl.sv */
module jetp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  jetp_pkg::status_t  status,
    output jetp_pkg::cmd_t     cmd
);
    import jetp_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.sel_init = 1'b1;
                state_next   = ST_START;
            end
            ST_START:
            begin
                cmd.load_start = 1'b1;
                state_next     = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (status.stop)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.update = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hdl/julia_escape_time_pixel_core.sv */
// Julia set escape-time core: evaluates one pixel per input beat.
// The input channel carries pixel_column and pixel_row; a beat is taken when
// in_valid is high and in_stall is low. The output channel returns
// escape_count with the echoed out_column and out_row; a beat is taken when
// out_valid is high and out_stall is low. Parameters (c, origin, step and the
// iteration limit) are written through cfg_write, cfg_index and cfg_data,
// and should only be changed while the core is idle.
// Each iteration passes through ST_MUL, the shared multiplier stage, and
// then ST_UPD, the saturating update and escape test; the first pass also
// forms the starting point through the same multipliers. The core works
// on one pixel at a time and takes the next beat in the cycle after a
// result is loaded.
// A finished result waits in the output register while the next pixel is
// accepted and evaluated; should that result still be stalled when the next
// one is ready, the core holds the new result until the output register is
// free, and the input stays stalled meanwhile.
// Reset clears all parameters to zero except the iteration limit, which
// becomes 256, and leaves no result pending.
module julia_escape_time_pixel_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [jetp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jetp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [jetp_pkg::IDX_W-1:0]        pixel_column,
    input  logic [jetp_pkg::IDX_W-1:0]        pixel_row,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [jetp_pkg::COUNT_WIDTH-1:0]  escape_count,
    output logic [jetp_pkg::IDX_W-1:0]        out_column,
    output logic [jetp_pkg::IDX_W-1:0]        out_row
);
    import jetp_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    jetp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jetp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    jetp_datapath u_datapath (
        .clk          (clk),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .escape_count (escape_count),
        .out_column   (out_column),
        .out_row      (out_row)
    );

endmodule
